FILE: design/assert_macros.svh
// Assertion helpers for the port checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/wpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_pkg
// Types, sizes and codes shared by the windowed peak pair finder modules.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int MAX_PEAKS       = 256;
  localparam int INDEX_BITS      = 16;
  localparam int AMP_BITS        = 24;
  localparam int ADDR_BITS       = $clog2(MAX_PEAKS);
  localparam int CNT_BITS        = ADDR_BITS + 1;
  localparam int RATIO_BITS      = 12;
  localparam int RATIO_FRAC_BITS = 8;
  localparam int WINDOW_BITS     = 12;
  localparam int PROD_BITS       = AMP_BITS + RATIO_BITS + 1;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QFILL_BITS      = QPTR_BITS + 1;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int WIDE_BITS       = (AMP_BITS > INDEX_BITS) ? AMP_BITS : INDEX_BITS;
  localparam int CFG_DATA_BITS   = (WIDE_BITS > RATIO_BITS) ? WIDE_BITS : RATIO_BITS;

  // Input mode codes.
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_EVAL   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MUON_THR       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MICHEL_THR     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RATIO      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COINC_WINDOW   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRE_MICHEL = 3'd5;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_EVAL,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUON,
    S_MICHEL,
    S_FINISH
  } back_state_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [INDEX_BITS-1:0]      peak_index;
    logic signed [AMP_BITS-1:0] peak_amplitude;
    logic [INDEX_BITS-1:0]      muon_bin;
    logic [INDEX_BITS-1:0]      decay_bin;
  } item_t;

  typedef struct packed {
    logic                  pair_found;
    logic [INDEX_BITS-1:0] first_index;
    logic [INDEX_BITS-1:0] second_index;
    logic                  second_valid;
    logic                  list_full;
  } result_t;

  typedef struct packed {
    logic signed [AMP_BITS-1:0] muon_threshold;
    logic signed [AMP_BITS-1:0] michel_threshold;
    logic [RATIO_BITS-1:0]      max_ratio_q8;
    logic [WINDOW_BITS-1:0]     coinc_window;
    logic [INDEX_BITS-1:0]      samples_in_waveform;
    logic                       require_michel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    muon_threshold:      AMP_BITS'(5000),
    michel_threshold:    AMP_BITS'(1000),
    max_ratio_q8:        RATIO_BITS'(256),
    coinc_window:        WINDOW_BITS'(40),
    samples_in_waveform: INDEX_BITS'(65535),
    require_michel:      1'b1
  };

  typedef struct packed {
    op_t                        op;
    logic [INDEX_BITS-1:0]      peak_index;
    logic signed [AMP_BITS-1:0] peak_amplitude;
    logic [INDEX_BITS-1:0]      muon_bin;
    logic [INDEX_BITS-1:0]      decay_bin;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

FILE: design/windowed_peak_pair_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_peak_pair_finder
// Stores peaks and pairs a muon peak with a Michel peak around tagged bins.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken at a clock edge with start high and
// busy low. Mode append stores a peak, clear empties the list, evaluate scans
// the list and returns one result; the unused mode is taken and ignored.
// Commands wait in a four-entry queue; busy is high only while it is full.
// The execution side takes one queued command per cycle while it is idle, so
// appends sustain one per cycle. An evaluation holds the execution side from
// its pop through a muon step for each stored peak it scans, a Michel step
// as well for each one neither below the muon window nor past the Michel
// window, and a finish step; a peak past the Michel window ends the scan
// early. The scan reads one peak per step through the registered read port.
// done pulses for one cycle with result, registered from the finish step.
// The receiver cannot stall: a result is valid only in its done cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Synchronous reset empties the queue and the peak
// list, clears the overflow flag and loads the default register values.
// ----------------------------------------------------------------------------
module windowed_peak_pair_finder import wpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  item_t                     item,
  output logic                      done,
  output result_t                   result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MUON_THR:       cfg.muon_threshold      <= cfg_data[AMP_BITS-1:0];
        REG_MICHEL_THR:     cfg.michel_threshold    <= cfg_data[AMP_BITS-1:0];
        REG_MAX_RATIO:      cfg.max_ratio_q8        <= cfg_data[RATIO_BITS-1:0];
        REG_COINC_WINDOW:   cfg.coinc_window        <= cfg_data[WINDOW_BITS-1:0];
        REG_SAMPLES:        cfg.samples_in_waveform <= cfg_data[INDEX_BITS-1:0];
        REG_REQUIRE_MICHEL: cfg.require_michel      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wpf_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .pop   (pop),
    .busy  (busy),
    .head  (head)
  );

  wpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

FILE: design/wpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_front
// Accepts command transactions, decodes the mode and queues the operations.
// ----------------------------------------------------------------------------
module wpf_front import wpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  input  logic        pop,
  output logic        busy,
  output queue_head_t head
);

  queue_entry_t           entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QFILL_BITS-1:0]  fill;
  op_t                    op;
  logic                   keep;
  logic                   push;
  logic                   do_pop;

  // The unused mode is taken and dropped here, so it never reaches the queue.
  always_comb begin
    case (item.mode)
      MODE_APPEND: begin
        op   = OP_APPEND;
        keep = 1'b1;
      end
      MODE_EVAL: begin
        op   = OP_EVAL;
        keep = 1'b1;
      end
      MODE_CLEAR: begin
        op   = OP_CLEAR;
        keep = 1'b1;
      end
      default: begin
        op   = OP_APPEND;
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = (fill == QFILL_BITS'(QUEUE_DEPTH));
  assign push       = start && !busy && keep;
  assign head.valid = (fill != '0);
  assign head.entry = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{
        op:             op,
        peak_index:     item.peak_index,
        peak_amplitude: item.peak_amplitude,
        muon_bin:       item.muon_bin,
        decay_bin:      item.decay_bin
      };
    end
  end

endmodule

FILE: design/wpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_back
// Executes queued operations: peak store writes, list clears and tag scans.
// ----------------------------------------------------------------------------
module wpf_back import wpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  output logic        done,
  output result_t     result
);

  logic [INDEX_BITS-1:0]      mem_index [MAX_PEAKS];
  logic signed [AMP_BITS-1:0] mem_amp   [MAX_PEAKS];
  logic [INDEX_BITS-1:0]      rd_ix;
  logic signed [AMP_BITS-1:0] rd_amp;
  logic [ADDR_BITS-1:0]       rd_addr;
  logic                       wr_en;

  back_state_t state, state_next;
  logic [CNT_BITS-1:0] count;
  logic                overflow;
  logic [CNT_BITS-1:0] k;
  logic [CNT_BITS-1:0] k_plus;
  logic                more;
  logic                start_eval;

  logic [INDEX_BITS-1:0] mu_lo, mi_lo;
  logic [INDEX_BITS:0]   mu_hi, mi_hi;

  logic                       mu_ok, mu2_ok, mi_ok, mi2_ok;
  logic signed [AMP_BITS-1:0] mu_amp, mu2_amp, mi_amp, mi2_amp;
  logic [INDEX_BITS-1:0]      mu_at, mi_at, mi2_at;
  logic [INDEX_BITS-1:0]      pk_ix;
  logic signed [AMP_BITS-1:0] pk_amp;

  logic past_end, before_start, mu_hit, mu_top;
  logic signed [PROD_BITS-1:0] ratio_prod, scaled_amp;
  logic ratio_ok, mi_hit, mi_top;

  logic                       same_peak, f_ok, pair, swap;
  logic signed [AMP_BITS-1:0] f_amp;
  logic [INDEX_BITS-1:0]      f_at;

  function automatic logic [INDEX_BITS-1:0] win_lo(
    input logic [INDEX_BITS-1:0]  bin,
    input logic [WINDOW_BITS-1:0] w
  );
    logic [INDEX_BITS:0] wide;
    wide = {1'b0, bin} - (INDEX_BITS + 1)'(w);
    return wide[INDEX_BITS] ? '0 : wide[INDEX_BITS-1:0];
  endfunction

  function automatic logic [INDEX_BITS:0] win_hi(
    input logic [INDEX_BITS-1:0]  bin,
    input logic [WINDOW_BITS-1:0] w,
    input logic [INDEX_BITS-1:0]  n
  );
    logic [INDEX_BITS:0] sum;
    sum = {1'b0, bin} + (INDEX_BITS + 1)'(w);
    if (sum > {1'b0, n}) begin
      return (n == '0) ? '0 : {1'b0, n - 1'b1};
    end
    return sum;
  endfunction

  // Peak store: one write port for appends, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_index[count[ADDR_BITS-1:0]] <= head.entry.peak_index;
      mem_amp[count[ADDR_BITS-1:0]]   <= head.entry.peak_amplitude;
    end
    rd_ix  <= mem_index[rd_addr];
    rd_amp <= mem_amp[rd_addr];
  end

  assign pop        = (state == S_IDLE) && head.valid;
  assign start_eval = pop && (head.entry.op == OP_EVAL);
  assign wr_en      = pop && (head.entry.op == OP_APPEND) &&
                      (count < CNT_BITS'(MAX_PEAKS));
  assign k_plus     = k + 1'b1;
  assign more       = (k_plus < count);
  assign rd_addr    = (state == S_IDLE) ? '0 : k_plus[ADDR_BITS-1:0];

  // Muon test on the peak just read from the store.
  assign past_end     = ({1'b0, rd_ix} > mi_hi);
  assign before_start = (rd_ix < mu_lo);
  assign mu_top       = !mu_ok || (rd_amp > mu_amp);
  assign mu_hit       = (rd_ix > mu_lo) && ({1'b0, rd_ix} < mu_hi) &&
                        (!mu2_ok || (rd_amp > mu2_amp)) && (rd_amp > cfg.muon_threshold);

  // Michel test in the following cycle, against the muon peak that includes this peak.
  assign ratio_prod = $signed({1'b0, cfg.max_ratio_q8}) * mu_amp;
  assign scaled_amp = {{(PROD_BITS - AMP_BITS - RATIO_FRAC_BITS){pk_amp[AMP_BITS-1]}},
                       pk_amp, {RATIO_FRAC_BITS{1'b0}}};
  assign ratio_ok   = (cfg.max_ratio_q8 == '0) ? pk_amp[AMP_BITS-1] :
                      (mu_ok && (scaled_amp < ratio_prod));
  assign mi_top     = !mi_ok || (pk_amp > mi_amp);
  assign mi_hit     = (pk_ix > mi_lo) && ({1'b0, pk_ix} < mi_hi) &&
                      (!mi2_ok || (pk_amp > mi2_amp)) &&
                      (pk_amp > cfg.michel_threshold) && ratio_ok;

  // When both choices are the same peak, the runner-up Michel peak stands in.
  assign same_peak = mu_ok && mi_ok && (mu_at == mi_at);
  assign f_ok      = same_peak ? mi2_ok  : mi_ok;
  assign f_amp     = same_peak ? mi2_amp : mi_amp;
  assign f_at      = same_peak ? mi2_at  : mi_at;
  assign pair      = mu_ok && (!cfg.require_michel || f_ok);
  assign swap      = f_ok && (mu_at > f_at) && !f_amp[AMP_BITS-1] && (f_amp != '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start_eval) begin
          state_next = (count == '0) ? S_FINISH : S_MUON;
        end
      end
      S_MUON: begin
        if (past_end) begin
          state_next = S_FINISH;
        end else if (before_start) begin
          state_next = more ? S_MUON : S_FINISH;
        end else begin
          state_next = S_MICHEL;
        end
      end
      S_MICHEL: state_next = more ? S_MUON : S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      if (pop) begin
        case (head.entry.op)
          OP_APPEND: begin
            if (wr_en) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
          OP_CLEAR: begin
            count    <= '0;
            overflow <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start_eval) begin
          mu_lo  <= win_lo(head.entry.muon_bin, cfg.coinc_window);
          mu_hi  <= win_hi(head.entry.muon_bin, cfg.coinc_window, cfg.samples_in_waveform);
          mi_lo  <= win_lo(head.entry.decay_bin, cfg.coinc_window);
          mi_hi  <= win_hi(head.entry.decay_bin, cfg.coinc_window, cfg.samples_in_waveform);
          mu_ok  <= 1'b0;
          mu2_ok <= 1'b0;
          mi_ok  <= 1'b0;
          mi2_ok <= 1'b0;
          mu_at  <= '0;
          mi_at  <= '0;
          mi2_at <= '0;
          k      <= '0;
        end
      end
      S_MUON: begin
        if (!past_end && before_start) begin
          k <= k_plus;
        end else if (!past_end) begin
          pk_ix  <= rd_ix;
          pk_amp <= rd_amp;
          if (mu_hit) begin
            if (mu_top) begin
              mu2_ok  <= mu_ok;
              mu2_amp <= mu_amp;
              mu_ok   <= 1'b1;
              mu_amp  <= rd_amp;
              mu_at   <= rd_ix;
            end else begin
              mu2_ok  <= 1'b1;
              mu2_amp <= rd_amp;
            end
          end
        end
      end
      S_MICHEL: begin
        k <= k_plus;
        if (mi_hit) begin
          if (mi_top) begin
            mi2_ok  <= mi_ok;
            mi2_amp <= mi_amp;
            mi2_at  <= mi_at;
            mi_ok   <= 1'b1;
            mi_amp  <= pk_amp;
            mi_at   <= pk_ix;
          end else begin
            mi2_ok  <= 1'b1;
            mi2_amp <= pk_amp;
            mi2_at  <= pk_ix;
          end
        end
      end
      S_FINISH: begin
        result.pair_found   <= pair;
        result.first_index  <= !pair ? '0 : (swap ? f_at : mu_at);
        result.second_index <= (pair && f_ok) ? (swap ? mu_at : f_at) : '0;
        result.second_valid <= pair && f_ok;
        result.list_full    <= overflow;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/wpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_port_checker
// Port-level checks on the result strobe and result fields of the finder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpf_port_checker import wpf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // An evaluation always passes through the finish step, so strobes are spaced.
  `ASSERT_CLK(a_done_spaced, clk, rst, done |=> !done, "back-to-back done strobes")

  `ASSERT_CLK(a_no_pair_zero, clk, rst, (done && !result.pair_found) |-> ((result.first_index == '0) && (result.second_index == '0) && !result.second_valid), "failed pair carries nonzero fields")

  `ASSERT_CLK(a_second_zero, clk, rst, (done && !result.second_valid) |-> (result.second_index == '0), "second index set without a Michel peak")

  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!done && !busy), "done or busy after reset")

endmodule

bind windowed_peak_pair_finder wpf_port_checker u_wpf_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: verif/wpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_checker
// Watches the command, result and register ports of the windowed peak pair
// finder. It keeps its own peak list and register copy, works out the pair
// for every evaluate transaction, and checks each result against the oldest
// pending one.
// ----------------------------------------------------------------------------
module wpf_checker import wpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  item_t                     item,
  input  logic                      done,
  input  result_t                   result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fail_count,
  output int                        open_count
);

  cfg_t                       regs;
  logic [INDEX_BITS-1:0]      peak_at [MAX_PEAKS];
  logic signed [AMP_BITS-1:0] peak_amp [MAX_PEAKS];
  int                         peak_total;
  logic                       store_overflow;
  result_t                    pair_q[$];
  result_t                    want;

  // Both window bounds are exclusive; the end clamps to the last sample.
  function automatic void tag_window(input int bin, output int lo, output int hi);
    int w;
    int n;
    w = int'(regs.coinc_window);
    n = int'(regs.samples_in_waveform);
    lo = (bin < w) ? 0 : bin - w;
    if (bin + w > n) begin
      hi = (n == 0) ? 0 : n - 1;
    end else begin
      hi = bin + w;
    end
  endfunction

  function automatic result_t predict_pair(input item_t it);
    int      mu_lo, mu_hi, mi_lo, mi_hi, ix, k;
    int      mu_at, mi_at, mi2_at, lead, trail;
    longint  a, mu_thr, mi_thr, ratio, mu_amp, mu2_amp, mi_amp, mi2_amp;
    bit      mu_ok, mu2_ok, mi_ok, mi2_ok, ratio_ok;
    result_t r;
    mu_ok = 0; mu2_ok = 0; mi_ok = 0; mi2_ok = 0;
    mu_amp = 0; mu2_amp = 0; mi_amp = 0; mi2_amp = 0;
    mu_at = 0; mi_at = 0; mi2_at = 0;
    mu_thr = longint'($signed(regs.muon_threshold));
    mi_thr = longint'($signed(regs.michel_threshold));
    ratio = longint'(regs.max_ratio_q8);
    tag_window(int'(it.muon_bin), mu_lo, mu_hi);
    tag_window(int'(it.decay_bin), mi_lo, mi_hi);
    for (k = 0; k < peak_total; k++) begin
      ix = int'(peak_at[k]);
      a = longint'(peak_amp[k]);
      if (ix > mi_hi) break;
      if (ix < mu_lo) continue;
      if (ix > mu_lo && ix < mu_hi && (!mu2_ok || a > mu2_amp) && a > mu_thr) begin
        if (!mu_ok || a > mu_amp) begin
          mu2_ok = mu_ok;
          mu2_amp = mu_amp;
          mu_ok = 1;
          mu_amp = a;
          mu_at = ix;
        end else begin
          mu2_ok = 1;
          mu2_amp = a;
        end
      end
      // A zero ratio limit only lets negative amplitudes through.
      if (ratio == 0) begin
        ratio_ok = (a < 0);
      end else begin
        ratio_ok = mu_ok && (a * 256 < ratio * mu_amp);
      end
      if (ix > mi_lo && ix < mi_hi && (!mi2_ok || a > mi2_amp) && a > mi_thr && ratio_ok) begin
        if (!mi_ok || a > mi_amp) begin
          mi2_ok = mi_ok;
          mi2_amp = mi_amp;
          mi2_at = mi_at;
          mi_ok = 1;
          mi_amp = a;
          mi_at = ix;
        end else begin
          mi2_ok = 1;
          mi2_amp = a;
          mi2_at = ix;
        end
      end
    end
    // When both picks are the same peak, the runner-up Michel peak stands in.
    if (mu_ok && mi_ok && mu_at == mi_at) begin
      mi_ok = mi2_ok;
      mi_amp = mi2_amp;
      mi_at = mi2_at;
    end
    r = '0;
    if (mu_ok && (!regs.require_michel || mi_ok)) begin
      lead = mu_at;
      trail = mi_at;
      if (mi_ok && mu_at > mi_at && mi_amp > 0) begin
        lead = mi_at;
        trail = mu_at;
      end
      r.pair_found = 1'b1;
      r.first_index = INDEX_BITS'(lead);
      r.second_index = mi_ok ? INDEX_BITS'(trail) : '0;
      r.second_valid = mi_ok;
    end
    r.list_full = store_overflow;
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = CFG_RESET;
      peak_total = 0;
      store_overflow = 1'b0;
      pair_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (pair_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no evaluation pending, expected none, actual %p",
                   $time, result);
        end else begin
          want = pair_q.pop_front();
          fail_count += field_diff("pair_found", 32'(want.pair_found),
                                   32'(result.pair_found));
          fail_count += field_diff("first_index", 32'(want.first_index),
                                   32'(result.first_index));
          fail_count += field_diff("second_index", 32'(want.second_index),
                                   32'(result.second_index));
          fail_count += field_diff("second_valid", 32'(want.second_valid),
                                   32'(result.second_valid));
          fail_count += field_diff("list_full", 32'(want.list_full),
                                   32'(result.list_full));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MUON_THR:       regs.muon_threshold = cfg_data[AMP_BITS-1:0];
          REG_MICHEL_THR:     regs.michel_threshold = cfg_data[AMP_BITS-1:0];
          REG_MAX_RATIO:      regs.max_ratio_q8 = cfg_data[RATIO_BITS-1:0];
          REG_COINC_WINDOW:   regs.coinc_window = cfg_data[WINDOW_BITS-1:0];
          REG_SAMPLES:        regs.samples_in_waveform = cfg_data[INDEX_BITS-1:0];
          REG_REQUIRE_MICHEL: regs.require_michel = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (item.mode)
          MODE_APPEND: begin
            if (peak_total < MAX_PEAKS) begin
              peak_at[peak_total] = item.peak_index;
              peak_amp[peak_total] = item.peak_amplitude;
              peak_total++;
            end else begin
              store_overflow = 1'b1;
            end
          end
          MODE_CLEAR: begin
            peak_total = 0;
            store_overflow = 1'b0;
          end
          MODE_EVAL: pair_q.insert(pair_q.size(), predict_pair(item));
          default: ;
        endcase
      end
    end
    open_count = pair_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the windowed peak pair finder with waveforms of ascending peaks,
// clears and evaluate tags, under several register settings and idle
// patterns, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tb_top;
  import wpf_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  item_t                     item;
  logic                      done;
  result_t                   result;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        fail_count;
  int                        open_count;

  int sent;
  int idle_pct;
  int next_index;
  int peak_log[$];

  windowed_peak_pair_finder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wpf_checker pair_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_count(open_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance, or later when an idle gap follows.
  // start stays high when no gap follows, so back-to-back commands work.
  task automatic issue(input item_t t);
    start <= 1'b1;
    item <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  function automatic item_t noise_item(input logic [1:0] mode);
    item_t t;
    t.mode = mode;
    t.peak_index = INDEX_BITS'($urandom);
    t.peak_amplitude = AMP_BITS'($urandom);
    t.muon_bin = INDEX_BITS'($urandom);
    t.decay_bin = INDEX_BITS'($urandom);
    return t;
  endfunction

  task automatic append_peak(input int ix, input int amp);
    item_t t;
    t = noise_item(MODE_APPEND);
    t.peak_index = INDEX_BITS'(ix);
    t.peak_amplitude = AMP_BITS'(amp);
    issue(t);
  endtask

  task automatic evaluate(input int muon_bin, input int decay_bin);
    item_t t;
    t = noise_item(MODE_EVAL);
    t.muon_bin = INDEX_BITS'(muon_bin);
    t.decay_bin = INDEX_BITS'(decay_bin);
    issue(t);
  endtask

  function automatic int random_amp();
    logic signed [AMP_BITS-1:0] v;
    int r;
    r = $urandom_range(99);
    v = AMP_BITS'($urandom);
    if (r < 70) return $urandom_range(0, 24000) - 4000;
    if (r < 90) return int'(v);
    return (r < 95) ? -8388608 : 8388607;
  endfunction

  // Waits until every evaluation has come back and the command queue has
  // drained its trailing appends and clears.
  task automatic drain();
    start <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(val);
    @(negedge clk);
  endtask

  task automatic apply_settings(input int mu_thr, input int mi_thr, input int ratio,
                                input int half_width, input int samples, input int need_mi);
    drain();
    write_reg(REG_MUON_THR, mu_thr);
    write_reg(REG_MICHEL_THR, mi_thr);
    write_reg(REG_MAX_RATIO, ratio);
    write_reg(REG_COINC_WINDOW, half_width);
    write_reg(REG_SAMPLES, samples);
    write_reg(REG_REQUIRE_MICHEL, need_mi);
    cfg_we <= 1'b0;
  endtask

  // Tags mostly sit on a stored peak, with the Michel bin a little later.
  task automatic eval_near();
    int mb;
    if (peak_log.size() == 0 || $urandom_range(9) == 0) begin
      evaluate($urandom_range(0, 65535), $urandom_range(0, 65535));
    end else begin
      mb = peak_log[$urandom_range(0, peak_log.size() - 1)] + $urandom_range(0, 10) - 5;
      evaluate(mb, mb + $urandom_range(0, 140) - 20);
    end
  endtask

  // A tidy waveform starts with a clear and keeps indices ascending; an untidy
  // one piles onto the current list and sometimes jumps backward.
  task automatic waveform(input int n_peaks, input int step_max, input bit tidy);
    int ix, k;
    ix = next_index;
    if (tidy) begin
      issue(noise_item(MODE_CLEAR));
      peak_log.delete();
      ix = ($urandom_range(9) == 0) ? $urandom_range(60000, 65000) : $urandom_range(0, 3000);
    end
    for (k = 0; k < n_peaks; k++) begin
      if (!tidy && $urandom_range(9) == 0) begin
        ix = $urandom_range(0, 65535);
      end else begin
        ix += $urandom_range(1, step_max);
      end
      if (ix > 65535) break;
      append_peak(ix, random_amp());
      peak_log.insert(peak_log.size(), ix);
      if ($urandom_range(7) == 0) eval_near();
      if ($urandom_range(29) == 0) issue(noise_item(MODE_UNUSED));
    end
    next_index = (ix > 65535) ? 65535 : ix;
    repeat ($urandom_range(1, 3)) eval_near();
  endtask

  task automatic run_phase(input int p);
    int quota, n, r;
    case (p)
      1: apply_settings(-8388608, -8388608, 4095, 4095, 65535, 0);
      2: apply_settings(8388607, 8388607, 0, 0, 1, 1);
      3: apply_settings(3000, -5000, 0, 60, 0, 1);
      4: apply_settings(5000, 1000, 256, 40, 4000, 1);
      default: apply_settings($urandom_range(0, 12000) - 2000, $urandom_range(0, 6000) - 1000,
                              ($urandom_range(1) == 0) ? $urandom_range(0, 1024)
                                                       : $urandom_range(0, 4095),
                              $urandom_range(0, 200),
                              ($urandom_range(1) == 0) ? 65535 : $urandom_range(1, 65535),
                              $urandom_range(0, 1));
    endcase
    case (p % 3)
      0: idle_pct = 0;
      1: idle_pct = 62;
      default: idle_pct = 15;
    endcase
    // One phase overfills the peak store so that appends are dropped.
    if (p == 5) waveform(262, 200, 1'b1);
    quota = sent + 170;
    while (sent < quota) begin
      r = $urandom_range(99);
      n = (r < 80) ? $urandom_range(1, 20) : $urandom_range(20, 60);
      waveform(n, ($urandom_range(4) == 0) ? 3000 : 30, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    int p;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    idle_pct = 0;
    next_index = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed checks under the reset register values.
    evaluate(0, 65535);
    issue(noise_item(MODE_UNUSED));
    append_peak(0, -8388608);
    append_peak(60, 8000);
    append_peak(70, 3000);
    append_peak(80, 9000);
    evaluate(70, 75);
    evaluate(60, 60);
    append_peak(65535, 8388607);
    evaluate(65535, 65535);
    evaluate(0, 0);
    issue(noise_item(MODE_CLEAR));
    evaluate(70, 75);
    append_peak(100, 6000);
    append_peak(101, 6000);
    evaluate(100, 100);
    // A ratio above one lets the muon peak win the Michel pick as well.
    apply_settings(5000, 1000, 512, 40, 65535, 0);
    issue(noise_item(MODE_CLEAR));
    append_peak(200, 7000);
    append_peak(210, 6000);
    evaluate(205, 205);
    append_peak(230, 9000);
    evaluate(225, 200);

    p = 1;
    while (sent < 2000) begin
      run_phase(p);
      p++;
    end

    drain();
    repeat (600) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: windowed_peak_pair_finder.f
+incdir+design
design/wpf_pkg.sv
design/wpf_front.sv
design/wpf_back.sv
design/windowed_peak_pair_finder.sv
design/wpf_checker.sv
verif/wpf_checker.sv
verif/tb_top.sv
